FILE: hdl/wrh_pkg.sv
// ----------------------------------------------------------------------------
// wrh_pkg
// Shared types and constants of the 2-D rolling window hash.
// ----------------------------------------------------------------------------
package wrh_pkg;

   localparam int unsigned WINDOW_SIZE = 64;
   localparam int unsigned HASH_W      = 64;
   localparam int unsigned PIXEL_W     = 32;
   localparam int unsigned WIDTH_W     = 13;
   localparam int unsigned WIN_X_W     = 12;
   localparam int unsigned ROW_W       = 16;
   localparam logic [ROW_W-1:0] ROW_MAX = '1;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd4096;

   typedef logic [HASH_W-1:0] hash_type;

   typedef struct packed {
      hash_type             window_hash;
      logic [WIN_X_W-1:0]   window_x;
      logic [ROW_W-1:0]     window_y;
   } rsp_type;

   // one column store word: frame mark above the hash
   typedef struct packed {
      logic     mark;
      hash_type hash;
   } col_word_type;

   // multiply by 62 as shift and subtract
   function automatic hash_type times62(input hash_type v);
      times62 = (v << 6) - (v << 1);
   endfunction

endpackage

FILE: hdl/window_rolling_hash_2d.sv
// ----------------------------------------------------------------------------
// window_rolling_hash_2d
// 2-D rolling hash over a raster pixel stream, giving 64x64 window hashes.
// ----------------------------------------------------------------------------
// Usage: pixels enter on the req_ channel in raster order, req_frame_start
// marking the first pixel of an image. Once the current column and row are
// both at least 63, the pixel yields one response on the rsp_ channel: the
// hash of the 64x64 window ending at it and the window's top-left corner.
// Other pixels yield no response. csr_wr_data sets the image width; the user
// must write it only while the block is idle: the block does not enforce this.
// Throughput: one pixel per cycle while req_ready is high. The row hash
// updates in the accept cycle; the column store read issued then returns in
// the next cycle, where the column hash is updated and written back, with
// forwarding when the same column is touched on consecutive cycles. A
// response is registered from the second stage into the response queue.
// Reset: the column store is swept to zero, one entry per cycle, over all
// MAX_WIDTH entries; req_ready stays low until the sweep is done.
// Stall: a three-entry response queue decouples the channels; requests
// keep being accepted until the queue plus the item in flight would be full.
// ----------------------------------------------------------------------------
module window_rolling_hash_2d #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [wrh_pkg::PIXEL_W-1:0]   req_pixel,
   input  logic                          req_frame_start,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [wrh_pkg::HASH_W-1:0]    rsp_window_hash,
   output logic [wrh_pkg::WIN_X_W-1:0]   rsp_window_x,
   output logic [wrh_pkg::ROW_W-1:0]     rsp_window_y,
   input  logic                          csr_wr_en,
   input  logic [wrh_pkg::WIDTH_W-1:0]   csr_wr_data
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int WW   = CW + 1;
   localparam int CMPW = (WW > wrh_pkg::WIDTH_W) ? WW : wrh_pkg::WIDTH_W;
   localparam int QD   = 3;

   // configuration
   logic [wrh_pkg::WIDTH_W-1:0] width_ff;
   logic [CMPW-1:0]             width_ext;
   logic [WW-1:0]               eff_width;

   // reset sweep
   logic          clr_busy_ff, clr_busy_in;
   logic [CW-1:0] clr_idx_ff, clr_idx_in;

   // front stage state
   logic                      parity_ff, parity_in;
   logic [CW-1:0]             col_ff, col_in;
   logic [wrh_pkg::ROW_W-1:0] row_ff, row_in;
   wrh_pkg::hash_type         racc_ff, racc_in;

   logic                      accept;
   logic                      parity_cur;
   logic [CW-1:0]             col_cur;
   logic [wrh_pkg::ROW_W-1:0] row_cur;
   logic [WW-1:0]             col_plus;
   wrh_pkg::hash_type         racc_base;
   logic                      emit_cur;
   logic [CW-1:0]             x_diff;

   // second stage
   logic                      s1_v_ff, s1_v_in;
   logic                      s1_emit_ff;
   logic [CW-1:0]             s1_col_ff;
   logic                      s1_parity_ff;
   wrh_pkg::hash_type         s1_racc_ff;
   logic [wrh_pkg::WIN_X_W-1:0] s1_x_ff;
   logic [wrh_pkg::ROW_W-1:0]   s1_y_ff;

   // last write, for forwarding
   logic                      lw_v_ff;
   logic [CW-1:0]             lw_col_ff;
   wrh_pkg::col_word_type     lw_word_ff;

   wrh_pkg::col_word_type     rd_word;
   wrh_pkg::col_word_type     cur_word;
   wrh_pkg::col_word_type     new_word;
   wrh_pkg::hash_type         prev_hash;

   // memory port
   logic                      mem_wr_en;
   logic [CW-1:0]             mem_wr_addr;
   wrh_pkg::col_word_type     mem_wr_data;

   // response queue
   wrh_pkg::rsp_type          q_ff [QD];
   logic [1:0]                q_wr_ff, q_wr_in;
   logic [1:0]                q_rd_ff, q_rd_in;
   logic [1:0]                q_cnt_ff, q_cnt_in;
   logic                      q_push, q_pop;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= wrh_pkg::WIDTH_RESET;
      end else if (csr_wr_en) begin
         width_ff <= csr_wr_data;
      end
   end

   always_comb begin
      width_ext = CMPW'(width_ff);
      if (width_ext == '0) begin
         eff_width = WW'(1);
      end else if (width_ext > CMPW'(MAX_WIDTH)) begin
         eff_width = WW'(MAX_WIDTH);
      end else begin
         eff_width = WW'(width_ext);
      end
   end

   // ---------------------------------------------------------------- front
   assign req_ready = !clr_busy_ff && !(q_cnt_ff == 2'd3)
                      && !(q_cnt_ff == 2'd2 && s1_v_ff && s1_emit_ff);
   assign accept    = req_valid && req_ready;

   always_comb begin
      parity_cur = parity_ff ^ req_frame_start;
      col_cur    = req_frame_start ? '0 : col_ff;
      row_cur    = req_frame_start ? '0 : row_ff;
      racc_base  = (col_cur == '0) ? '0 : racc_ff;
      col_plus   = WW'(col_cur) + WW'(1);
      emit_cur   = (col_cur >= CW'(wrh_pkg::WINDOW_SIZE - 1))
                   && (row_cur >= wrh_pkg::ROW_W'(wrh_pkg::WINDOW_SIZE - 1));
      x_diff     = col_cur - CW'(wrh_pkg::WINDOW_SIZE - 1);

      parity_in = parity_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      racc_in   = racc_ff;
      if (accept) begin
         parity_in = parity_cur;
         racc_in   = wrh_pkg::times62(racc_base)
                     + wrh_pkg::HASH_W'(req_pixel);
         if (col_plus >= eff_width) begin
            col_in = '0;
            row_in = (row_cur == wrh_pkg::ROW_MAX) ? row_cur
                                                   : row_cur + 1'b1;
         end else begin
            col_in = col_plus[CW-1:0];
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         racc_ff   <= '0;
      end else begin
         parity_ff <= parity_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         racc_ff   <= racc_in;
      end
   end

   // ---------------------------------------------------------------- sweep
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == CW'(MAX_WIDTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // ---------------------------------------------------------------- column store
   wrh_ram #(
      .WIDTH ($bits(wrh_pkg::col_word_type)),
      .DEPTH (MAX_WIDTH)
   ) u_col_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (rd_word)
   );

   // ---------------------------------------------------------------- second stage
   assign s1_v_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         lw_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         lw_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff   <= emit_cur;
         s1_col_ff    <= col_cur;
         s1_parity_ff <= parity_cur;
         s1_racc_ff   <= racc_in;
         s1_x_ff      <= wrh_pkg::WIN_X_W'(x_diff);
         s1_y_ff      <= row_cur - wrh_pkg::ROW_W'(wrh_pkg::WINDOW_SIZE - 1);
      end
      lw_col_ff  <= s1_col_ff;
      lw_word_ff <= new_word;
   end

   always_comb begin
      cur_word      = (lw_v_ff && lw_col_ff == s1_col_ff) ? lw_word_ff : rd_word;
      prev_hash     = (cur_word.mark == s1_parity_ff) ? cur_word.hash : '0;
      new_word.mark = s1_parity_ff;
      new_word.hash = wrh_pkg::times62(prev_hash) + s1_racc_ff;

      mem_wr_en = clr_busy_ff || s1_v_ff;
      if (clr_busy_ff) begin
         mem_wr_addr = clr_idx_ff;
         mem_wr_data = '0;
      end else begin
         mem_wr_addr = s1_col_ff;
         mem_wr_data = new_word;
      end
   end

   // ---------------------------------------------------------------- response queue
   assign q_push = s1_v_ff && s1_emit_ff;
   assign q_pop  = rsp_valid && rsp_ready;

   always_comb begin
      q_wr_in  = q_wr_ff;
      q_rd_in  = q_rd_ff;
      q_cnt_in = q_cnt_ff;
      if (q_push) begin
         q_wr_in = (q_wr_ff == 2'(QD - 1)) ? 2'd0 : q_wr_ff + 2'd1;
      end
      if (q_pop) begin
         q_rd_in = (q_rd_ff == 2'(QD - 1)) ? 2'd0 : q_rd_ff + 2'd1;
      end
      if (q_push && !q_pop) begin
         q_cnt_in = q_cnt_ff + 2'd1;
      end else if (q_pop && !q_push) begin
         q_cnt_in = q_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         q_wr_ff  <= q_wr_in;
         q_rd_ff  <= q_rd_in;
         q_cnt_ff <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_ff[q_wr_ff].window_hash <= new_word.hash;
         q_ff[q_wr_ff].window_x    <= s1_x_ff;
         q_ff[q_wr_ff].window_y    <= s1_y_ff;
      end
   end

   assign rsp_valid       = (q_cnt_ff != 2'd0);
   assign rsp_window_hash = q_ff[q_rd_ff].window_hash;
   assign rsp_window_x    = q_ff[q_rd_ff].window_x;
   assign rsp_window_y    = q_ff[q_rd_ff].window_y;

endmodule

FILE: hdl/wrh_ram.sv
// ----------------------------------------------------------------------------
// wrh_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module wrh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: hdl/wrh_checker.sv
// ----------------------------------------------------------------------------
// wrh_checker
// Port-level checks of the 2-D rolling window hash, bound to the top level.
// ----------------------------------------------------------------------------
module wrh_checker #(
   parameter int MAX_WIDTH = 4096
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [wrh_pkg::HASH_W-1:0]    rsp_window_hash,
   input logic [wrh_pkg::WIN_X_W-1:0]   rsp_window_x,
   input logic [wrh_pkg::ROW_W-1:0]     rsp_window_y
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_window_hash)
         && $stable(rsp_window_x) && $stable(rsp_window_y))
      else $error("response changed while stalled");

   // store sweep blocks requests right after reset
   a_sweep: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted during store sweep");

   // a rising response follows an accepted request via the second stage and queue
   a_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without matching request");

   // window corner stays inside the image
   a_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_window_y <= wrh_pkg::ROW_MAX
                     - wrh_pkg::ROW_W'(wrh_pkg::WINDOW_SIZE - 1))
                 && (32'(rsp_window_x) <= 32'(MAX_WIDTH - wrh_pkg::WINDOW_SIZE)))
      else $error("window corner out of range");

endmodule

bind window_rolling_hash_2d wrh_checker #(.MAX_WIDTH(MAX_WIDTH)) u_wrh_checker (.*);

FILE: test/tb_window_rolling_hash_2d.sv
// ----------------------------------------------------------------------------
// tb_window_rolling_hash_2d
// Self-checking bench for the 2-D rolling window hash.
// ----------------------------------------------------------------------------
// Pixels go in as requests with random gaps. A scoreboard object keeps its
// own row hash, column store and counters and predicts each 64x64 window
// result, and checks every response against it in order. The run covers a
// short directed opening, one-column rows that lift the row counter quickly,
// wide and narrow rows that then yield windows, and short bursts at many
// widths changed mid-row, with back-pressure on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_window_rolling_hash_2d;

   localparam int unsigned       MAX_COLS    = 4096;
   localparam int unsigned       STALL_LIMIT = 20000;
   localparam wrh_pkg::hash_type MULTIPLIER  = 64'd62;

   class hash_window_tracker;
      wrh_pkg::hash_type           column_hash [MAX_COLS];
      bit                          column_mark [MAX_COLS];
      bit                          parity;
      wrh_pkg::hash_type           line_hash;
      int unsigned                 column;
      int unsigned                 row;
      logic [wrh_pkg::WIDTH_W-1:0] image_width;
      wrh_pkg::rsp_type            expected_windows [$];
      int unsigned                 windows_expected;
      int unsigned                 windows_checked;
      int unsigned                 mismatches;

      function new();
         foreach (column_hash[i]) begin
            column_hash[i] = '0;
            column_mark[i] = 1'b0;
         end
         parity           = 1'b0;
         line_hash        = '0;
         column           = 0;
         row              = 0;
         image_width      = wrh_pkg::WIDTH_RESET;
         windows_expected = 0;
         windows_checked  = 0;
         mismatches       = 0;
      endfunction

      function int unsigned pending();
         return expected_windows.size();
      endfunction

      function void take_pixel(input logic [wrh_pkg::PIXEL_W-1:0] pix, input logic new_frame);
         int unsigned       c;
         int unsigned       span;
         wrh_pkg::hash_type h;
         wrh_pkg::rsp_type  w;
         if (new_frame) begin
            parity    = ~parity;
            column    = 0;
            row       = 0;
            line_hash = '0;
         end
         if (column >= MAX_COLS) column = 0;
         c = column;
         if (c == 0) line_hash = '0;
         line_hash = line_hash * MULTIPLIER + wrh_pkg::HASH_W'(pix);
         h = (column_mark[c] == parity) ? column_hash[c] : '0;
         h = h * MULTIPLIER + line_hash;
         column_hash[c] = h;
         column_mark[c] = parity;
         if (c >= wrh_pkg::WINDOW_SIZE - 1 && row >= wrh_pkg::WINDOW_SIZE - 1) begin
            w.window_hash = h;
            w.window_x    = wrh_pkg::WIN_X_W'(c - (wrh_pkg::WINDOW_SIZE - 1));
            w.window_y    = wrh_pkg::ROW_W'(row - (wrh_pkg::WINDOW_SIZE - 1));
            expected_windows.push_back(w);
            windows_expected++;
         end
         // zero width acts as one column, oversized as the full store
         if (image_width == 0) span = 1;
         else if (image_width > MAX_COLS) span = MAX_COLS;
         else span = image_width;
         if (c + 1 >= span) begin
            column = 0;
            if (row < wrh_pkg::ROW_MAX) row++;
         end else begin
            column = c + 1;
         end
      endfunction

      function void check_window(input wrh_pkg::rsp_type got);
         wrh_pkg::rsp_type want;
         if (expected_windows.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected window: hash %h x %0d y %0d",
                        got.window_hash, got.window_x, got.window_y);
            return;
         end
         want = expected_windows.pop_front();
         windows_checked++;
         if (got.window_hash !== want.window_hash || got.window_x !== want.window_x ||
             got.window_y !== want.window_y) begin
            mismatches++;
            if (mismatches <= 10)
               $display("window %0d wrong: expected hash %h x %0d y %0d, got hash %h x %0d y %0d",
                        windows_checked, want.window_hash, want.window_x, want.window_y,
                        got.window_hash, got.window_x, got.window_y);
         end
      endfunction
   endclass

   logic                          clock           = 1'b0;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic                          req_ready;
   logic [wrh_pkg::PIXEL_W-1:0]   req_pixel       = '0;
   logic                          req_frame_start = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready       = 1'b0;
   logic [wrh_pkg::HASH_W-1:0]    rsp_window_hash;
   logic [wrh_pkg::WIN_X_W-1:0]   rsp_window_x;
   logic [wrh_pkg::ROW_W-1:0]     rsp_window_y;
   logic                          csr_wr_en       = 1'b0;
   logic [wrh_pkg::WIDTH_W-1:0]   csr_wr_data     = '0;

   hash_window_tracker windows = new();
   bit          steady_flow    = 1'b0;
   bit          bulk_mode      = 1'b0;
   int unsigned receiver_hold  = 0;
   int unsigned holds_done     = 0;
   int unsigned pixels_sent    = 0;
   int unsigned frames_started = 0;
   int unsigned idle_cycles    = 0;

   window_rolling_hash_2d #(
      .MAX_WIDTH(MAX_COLS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_window_hash (rsp_window_hash),
      .rsp_window_x    (rsp_window_x),
      .rsp_window_y    (rsp_window_y),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned draw_gap();
      return (bulk_mode || steady_flow) ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic logic [wrh_pkg::PIXEL_W-1:0] random_pixel();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // entered and left on a falling edge
   task automatic send_pixel(input logic [wrh_pkg::PIXEL_W-1:0] pix, input logic new_frame);
      int unsigned gap;
      if ($urandom_range(0, 63) == 0) steady_flow = !steady_flow;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel       <= pix;
      req_frame_start <= new_frame;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      windows.take_pixel(pix, new_frame);
      pixels_sent++;
      if (new_frame) frames_started++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (windows.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_width(input logic [wrh_pkg::WIDTH_W-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      windows.image_width = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : response_side
      int unsigned      stall;
      wrh_pkg::rsp_type got;
      @(negedge clock);
      forever begin
         stall = draw_gap();
         if (receiver_hold > 0) begin
            stall = receiver_hold;
            receiver_hold = 0;
            holds_done++;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.window_hash = rsp_window_hash;
         got.window_x    = rsp_window_x;
         got.window_y    = rsp_window_y;
         windows.check_window(got);
         @(negedge clock);
      end
   end

   initial begin : watchdog
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: nothing moved for %0d cycles, %0d windows outstanding",
                     STALL_LIMIT, windows.pending());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned                 n;
      int unsigned                 len;
      logic [wrh_pkg::WIDTH_W-1:0] width_steps [9];
      width_steps = '{13'd4096, 13'd100, 13'd0, 13'd8191, 13'd63, 13'd64, 13'd4097,
                      13'd4095, 13'd1};

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed opening: reset width, frame starts mid-row and back to back
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      send_pixel(32'h8000_0000, 1'b0);
      send_pixel(32'h0000_0001, 1'b1);
      send_pixel(32'hFFFF_FFFF, 1'b1);
      send_pixel(32'h1234_5678, 1'b1);
      repeat (3) send_pixel($urandom, 1'b0);
      write_width(13'd0);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'h5555_AAAA, 1'b1);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      write_width(13'h1FFF);
      repeat (4) send_pixel(random_pixel(), 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b1);

      // one-column rows lift the row counter, then one wide row yields windows
      write_width(13'd1);
      for (n = 0; n < 63; n++) send_pixel(random_pixel(), n == 0);
      write_width(13'd4096);
      bulk_mode = 1'b1;
      receiver_hold = 300;
      for (n = 0; n < 200; n++) send_pixel(random_pixel(), 1'b0);
      bulk_mode = 1'b0;

      // new frame, then narrow rows so the window row moves on
      write_width(13'd1);
      for (n = 0; n < 63; n++) send_pixel(random_pixel(), n == 0);
      write_width(wrh_pkg::WIDTH_W'($urandom_range(64, 72)));
      for (n = 0; n < 150; n++) send_pixel(random_pixel(), 1'b0);

      // short bursts, width changed between them
      for (n = 0; n < 24; n++) begin
         if (n < 9) write_width(width_steps[n]);
         else if ($urandom_range(0, 1) == 0) write_width(wrh_pkg::WIDTH_W'($urandom));
         else write_width(wrh_pkg::WIDTH_W'($urandom_range(60, 300)));
         len = $urandom_range(1, 24);
         repeat (len) send_pixel(random_pixel(), 1'b0);
      end

      settle();
      $display("covered %0d pixels over %0d frame starts, %0d windows checked",
               pixels_sent, frames_started, windows.windows_checked);
      $display("widths 0 to 8191 with mid-row changes, %0d long receiver stalls",
               holds_done);
      if (windows.pending() != 0)
         $display("%0d expected windows never arrived", windows.pending());
      if (windows.mismatches == 0 && windows.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", windows.mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/wrh_pkg.sv
hdl/wrh_ram.sv
hdl/window_rolling_hash_2d.sv
hdl/wrh_checker.sv
test/tb_window_rolling_hash_2d.sv
